// ----- hdl/fbl_pkg.sv -----
// Shared widths, constants and controller/datapath interface types for the factorial block.
package fbl_pkg;

    localparam int unsigned N_W         = 7;
    localparam int unsigned LIMB_W      = 14;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned PROD_W      = 21;
    localparam int unsigned RECIP_W     = 13;
    localparam int unsigned RP_W        = PROD_W + RECIP_W;
    localparam int unsigned Q_W         = 8;
    localparam int unsigned QK_W        = 22;
    localparam int unsigned REM_W       = 15;
    localparam int unsigned CARRY_W     = 8;
    localparam int unsigned RECIP_SHIFT = 26;

    localparam logic [LIMB_W-1:0]  LIMB_BASE = 14'd10000;
    localparam logic [LIMB_W-1:0]  LIMB_ONE  = 14'd1;
    localparam logic [N_W-1:0]     MAX_ARG   = 7'd100;
    localparam logic [N_W-1:0]     ARG_ONE   = 7'd1;
    // floor(2^26 / 10000): quotient estimate is exact or one low
    localparam logic [RECIP_W-1:0] RECIP     = 13'd6710;

    typedef struct packed {
        logic addr_clr;
        logic addr_inc;
        logic addr_top;
        logic addr_dec;
        logic load_n;
        logic m_init;
        logic m_inc;
        logic clr_carry;
        logic load_wr;
        logic issue;
        logic out_limb;
        logic out_err;
    } cmd_t;

    typedef struct packed {
        logic n_bad;
        logic addr_last;
        logic addr_zero;
        logic rd_zero;
        logic m_done;
        logic pipe_busy;
        logic out_free;
    } sts_t;

endpackage

// ----- hdl/fbl_dpath.sv -----
// Datapath: limb memory, multiply/divide pipeline, carry stage, counters and output register.
module fbl_dpath
    import fbl_pkg::*;
#(
    parameter int unsigned LIMBS = 40
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [N_W-1:0]    n,
    output logic [LIMB_W-1:0] limb_value,
    output logic [IDX_W-1:0]  limb_index,
    output logic              last,
    output logic              error,
    output logic              out_valid,
    input  logic              out_ready
);

    localparam int unsigned AW = (LIMBS > 1) ? $clog2(LIMBS) : 1;
    localparam logic [AW-1:0] ADDR_TOP = AW'(LIMBS - 1);

    logic [LIMB_W-1:0]  mem [LIMBS];
    logic [LIMB_W-1:0]  rd_data_reg;

    logic [N_W-1:0]     n_reg;
    logic [N_W-1:0]     m_reg, m_next;
    logic [AW-1:0]      addr_reg, addr_next;

    logic [4:0]         vld_reg;
    logic [AW-1:0]      tag_reg [5];

    logic [PROD_W-1:0]  prod_reg, p2_reg, p3_reg;
    logic [RP_W-1:0]    recip_prod;
    logic [Q_W-1:0]     q0_reg, q3_reg;
    logic [QK_W-1:0]    qk_reg;
    logic [QK_W-1:0]    rem_full;
    logic [REM_W-1:0]   rem;
    logic [LIMB_W-1:0]  lo_reg;
    logic [Q_W-1:0]     hi_reg;

    logic [CARRY_W-1:0] carry_reg, carry_next;
    logic [REM_W-1:0]   sum;
    logic [LIMB_W-1:0]  sum_lo;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [LIMB_W-1:0]  wr_data;

    logic [LIMB_W-1:0]  limb_value_reg;
    logic [IDX_W-1:0]   limb_index_reg;
    logic               last_reg;
    logic               error_reg;
    logic               out_valid_reg;

    // ---- limb memory ----
    always_comb
    begin
        wr_en   = cmd.load_wr | vld_reg[4];
        wr_addr = cmd.load_wr ? addr_reg : tag_reg[4];
        if (cmd.load_wr)
        begin
            wr_data = (addr_reg == '0) ? LIMB_ONE : '0;
        end
        else
        begin
            wr_data = sum_lo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // ---- counters ----
    always_comb
    begin
        addr_next = addr_reg;
        if (cmd.addr_clr)
        begin
            addr_next = '0;
        end
        else if (cmd.addr_top)
        begin
            addr_next = ADDR_TOP;
        end
        else if (cmd.addr_inc)
        begin
            addr_next = addr_reg + AW'(1);
        end
        else if (cmd.addr_dec)
        begin
            addr_next = addr_reg - AW'(1);
        end

        m_next = m_reg;
        if (cmd.m_init)
        begin
            m_next = ARG_ONE;
        end
        else if (cmd.m_inc)
        begin
            m_next = m_reg + ARG_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            m_reg    <= '0;
            n_reg    <= '0;
        end
        else
        begin
            addr_reg <= addr_next;
            m_reg    <= m_next;
            if (cmd.load_n)
            begin
                n_reg <= n;
            end
        end
    end

    // ---- pipeline valids and address tags ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], cmd.issue};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= addr_reg;
        for (int i = 1; i < 5; i++)
        begin
            tag_reg[i] <= tag_reg[i-1];
        end
    end

    // ---- multiply, reciprocal quotient estimate, remainder correction ----
    assign recip_prod = RP_W'(prod_reg) * RP_W'(RECIP);
    assign rem_full   = QK_W'(p3_reg) - qk_reg;
    assign rem        = rem_full[REM_W-1:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(m_reg) * PROD_W'(rd_data_reg);
        q0_reg   <= recip_prod[RECIP_SHIFT +: Q_W];
        p2_reg   <= prod_reg;
        qk_reg   <= QK_W'(q0_reg) * QK_W'(LIMB_BASE);
        q3_reg   <= q0_reg;
        p3_reg   <= p2_reg;
        if (rem >= REM_W'(LIMB_BASE))
        begin
            lo_reg <= LIMB_W'(rem - REM_W'(LIMB_BASE));
            hi_reg <= q3_reg + Q_W'(1);
        end
        else
        begin
            lo_reg <= rem[LIMB_W-1:0];
            hi_reg <= q3_reg;
        end
    end

    // ---- carry stage: only a narrow add and compare in the loop ----
    always_comb
    begin
        sum = REM_W'(lo_reg) + REM_W'(carry_reg);
        if (sum >= REM_W'(LIMB_BASE))
        begin
            sum_lo     = LIMB_W'(sum - REM_W'(LIMB_BASE));
            carry_next = CARRY_W'(hi_reg + Q_W'(1));
        end
        else
        begin
            sum_lo     = sum[LIMB_W-1:0];
            carry_next = CARRY_W'(hi_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else if (cmd.clr_carry)
        begin
            carry_reg <= '0;
        end
        else if (vld_reg[4])
        begin
            carry_reg <= carry_next;
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_limb || cmd.out_err)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_limb)
        begin
            limb_value_reg <= rd_data_reg;
            limb_index_reg <= IDX_W'(addr_reg);
            last_reg       <= (addr_reg == '0);
            error_reg      <= 1'b0;
        end
        else if (cmd.out_err)
        begin
            limb_value_reg <= '0;
            limb_index_reg <= '0;
            last_reg       <= 1'b1;
            error_reg      <= 1'b1;
        end
    end

    assign limb_value = limb_value_reg;
    assign limb_index = limb_index_reg;
    assign last       = last_reg;
    assign error      = error_reg;
    assign out_valid  = out_valid_reg;

    // ---- status ----
    always_comb
    begin
        sts.n_bad     = (n == '0) || (n > MAX_ARG);
        sts.addr_last = (addr_reg == ADDR_TOP);
        sts.addr_zero = (addr_reg == '0);
        sts.rd_zero   = (rd_data_reg == '0);
        sts.m_done    = (m_reg == n_reg);
        sts.pipe_busy = |vld_reg;
        sts.out_free  = !out_valid_reg || out_ready;
    end

`ifndef SYNTHESIS
    a_split_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (lo_reg < LIMB_BASE) && (hi_reg < Q_W'(MAX_ARG)))
        else $error("product split out of range");

    a_last_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg && !error_reg |-> limb_index_reg == '0)
        else $error("last flag on a limb other than limb 0");
`endif

endmodule

// ----- hdl/fbl_ctrl.sv -----
// Controller: sequences load, multiply passes, drain, limb emission and error beats.
module fbl_ctrl
    import fbl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_ERR  = 7'b0000010,
        ST_LOAD = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_PEND = 7'b0010000,
        ST_ERD  = 7'b0100000,
        ST_ECHK = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   lead_reg, lead_next;

    always_comb
    begin
        state_next = state_reg;
        lead_next  = lead_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.addr_clr = 1'b1;
                    cmd.load_n   = 1'b1;
                    cmd.m_init   = 1'b1;
                    state_next   = sts.n_bad ? ST_ERR : ST_LOAD;
                end
            end
            ST_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_err = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                cmd.load_wr = 1'b1;
                if (sts.addr_last)
                begin
                    cmd.addr_clr = 1'b1;
                    state_next   = ST_PEND;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                end
            end
            ST_MUL:
            begin
                cmd.issue = 1'b1;
                if (sts.addr_last)
                begin
                    state_next = ST_PEND;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                end
            end
            ST_PEND:
            begin
                if (!sts.pipe_busy)
                begin
                    if (sts.m_done)
                    begin
                        cmd.addr_top = 1'b1;
                        lead_next    = 1'b1;
                        state_next   = ST_ERD;
                    end
                    else
                    begin
                        cmd.m_inc     = 1'b1;
                        cmd.clr_carry = 1'b1;
                        cmd.addr_clr  = 1'b1;
                        state_next    = ST_MUL;
                    end
                end
            end
            ST_ERD:
            begin
                state_next = ST_ECHK;
            end
            ST_ECHK:
            begin
                if (lead_reg && sts.rd_zero && !sts.addr_zero)
                begin
                    // leading zero limb: skip it
                    cmd.addr_dec = 1'b1;
                    state_next   = ST_ERD;
                end
                else if (sts.out_free)
                begin
                    cmd.out_limb = 1'b1;
                    lead_next    = 1'b0;
                    if (sts.addr_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.addr_dec = 1'b1;
                        state_next   = ST_ERD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lead_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lead_reg  <= lead_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !sts.pipe_busy)
        else $error("pipeline busy while idle");

    a_mul_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |=> (state_reg == ST_MUL) || (state_reg == ST_PEND))
        else $error("multiply pass left without draining");
`endif

endmodule

// ----- hdl/factorial_base10000_limbs.sv -----
// Top level of the base-10000 factorial engine: controller plus datapath.
// Steps: load, then (n-1) multiply passes, then the limbs are read out. One limb per cycle
// through the shared multiply/divide pipeline; each pass drains before the next since
// limb 0 depends on it. An out-of-range n gives its single error beat once the output
// register is free.
// Reset (rst_n, asynchronous, active low) clears control state; limb memory is reloaded per item.
module factorial_base10000_limbs
    import fbl_pkg::*;
#(
    parameter int unsigned LIMBS = 40
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [N_W-1:0]    n,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [LIMB_W-1:0] limb_value,
    output logic [IDX_W-1:0]  limb_index,
    output logic              last,
    output logic              error
);

    // Command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // Sequencer: idle -> load one -> passes m = 2..n -> emit limbs, or idle -> one error beat.
    // A new beat is taken as soon as the final limb sits in the output register.
    fbl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: limb memory (one read, one write a cycle), five-stage
    // multiply and reciprocal-divide pipeline, then the narrow carry stage
    // which writes each new limb back.
    fbl_dpath #(
        .LIMBS (LIMBS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .n          (n),
        .limb_value (limb_value),
        .limb_index (limb_index),
        .last       (last),
        .error      (error),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

// ----- dv/factorial_base10000_limbs_checker.sv -----
// Checker for the factorial engine: predicts the limb beats of each argument and compares them.
module factorial_base10000_limbs_checker
    import fbl_pkg::*;
#(
    parameter int unsigned LIMBS = 40
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [N_W-1:0]    n,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [LIMB_W-1:0] limb_value,
    input  logic [IDX_W-1:0]  limb_index,
    input  logic              last,
    input  logic              error,
    output int                fault_count,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [LIMB_W-1:0] value;
        logic [IDX_W-1:0]  pos;
        logic              last;
        logic              error;
    } limb_beat_t;

    logic [LIMB_W-1:0] limb_store [LIMBS];
    limb_beat_t        expected_limbs [$];

    // Works out n! in base-10000 limbs and queues the beats it should give.
    task automatic push_factorial_limbs(input logic [N_W-1:0] arg);
        int unsigned acc;
        int unsigned carry;
        int          msl;
        limb_beat_t  beat;
        if (arg == '0 || arg > MAX_ARG)
        begin
            // out of range: one error beat, store untouched
            beat.value = '0;
            beat.pos   = '0;
            beat.last  = 1'b1;
            beat.error = 1'b1;
            expected_limbs.push_back(beat);
            return;
        end
        foreach (limb_store[k])
            limb_store[k] = '0;
        limb_store[0] = LIMB_ONE;
        for (int m = 2; m <= int'(arg); m++)
        begin
            carry = 0;
            for (int k = 0; k < int'(LIMBS); k++)
            begin
                acc           = m * limb_store[k] + carry;
                limb_store[k] = LIMB_W'(acc % LIMB_BASE);
                carry         = acc / LIMB_BASE;
            end
            // carry out of the top limb is lost
        end
        msl = LIMBS - 1;
        while (msl > 0 && limb_store[msl] == '0)
            msl--;
        for (int k = msl; k >= 0; k--)
        begin
            beat.value = limb_store[k];
            beat.pos   = IDX_W'(k);
            beat.last  = (k == 0);
            beat.error = 1'b0;
            expected_limbs.push_back(beat);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        limb_beat_t want;
        if (!rst_n)
        begin
            expected_limbs.delete();
            foreach (limb_store[k])
                limb_store[k] = '0;
            fault_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_limbs.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("%0t: unexpected beat value=%0d index=%0d last=%0b error=%0b",
                                 $realtime, limb_value, limb_index, last, error);
                end
                else
                begin
                    want = expected_limbs.pop_front();
                    if (limb_value !== want.value || limb_index !== want.pos ||
                        last !== want.last || error !== want.error)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                            $display({"%0t: beat mismatch: value exp %0d got %0d, index exp %0d ",
                                      "got %0d, last exp %0b got %0b, error exp %0b got %0b"},
                                     $realtime, want.value, limb_value, want.pos, limb_index,
                                     want.last, last, want.error, error);
                    end
                end
            end
            if (in_valid && in_ready)
                push_factorial_limbs(n);
            outstanding = expected_limbs.size();
        end
    end

endmodule

// ----- dv/factorial_base10000_limbs_tb.sv -----
// Testbench top for the base-10000 factorial engine: stimulus, back-pressure and verdict.
module factorial_base10000_limbs_tb
    import fbl_pkg::*;
#(
    parameter int unsigned LIMBS = 40
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ARGS  = 135;
    localparam int MAX_GAP      = 18;
    // longest sensible quiet stretch: a full n = 100 run sat behind
    // the long receiver hold-off, with generous margin on top
    localparam int QUIET_LIMIT  = 40000;
    localparam int HOLD_AT_BEAT = 400;
    localparam int HOLD_CYCLES  = 1500;
    // settling time after the last beat; this leaves room for any stray beats
    localparam int SETTLE       = 64;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [N_W-1:0]    n;
    logic              out_valid;
    logic              out_ready;
    logic [LIMB_W-1:0] limb_value;
    logic [IDX_W-1:0]  limb_index;
    logic              last;
    logic              error;

    int fault_count;
    int outstanding;
    int quiet_cycles;

    // run statistics for the summary
    int args_sent;
    int bad_args_sent;
    int largest_arg;
    int beats_taken;
    int drains;

    always #(CLK_PERIOD / 2) clk = ~clk;

    factorial_base10000_limbs #(
        .LIMBS (LIMBS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .n          (n),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .limb_value (limb_value),
        .limb_index (limb_index),
        .last       (last),
        .error      (error)
    );

    factorial_base10000_limbs_checker #(
        .LIMBS (LIMBS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .n           (n),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .limb_value  (limb_value),
        .limb_index  (limb_index),
        .last        (last),
        .error       (error),
        .fault_count (fault_count),
        .outstanding (outstanding)
    );

    // Offer one argument after a random idle gap (none in burst mode) and hold it until the beat is taken.
    // Inputs move on the falling edge only; the handshake is looked at on the rising edge.
    task automatic send_arg(input int arg, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        n        <= N_W'(arg);
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        args_sent++;
        if (arg == 0 || arg > int'(MAX_ARG))
            bad_args_sent++;
        else if (arg > largest_arg)
            largest_arg = arg;
    endtask

    // Sender goes quiet until every predicted beat has been seen.
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        drains++;
    endtask

    initial
    begin : stimulus
        int directed_args [21];
        int arg;
        int pick;
        bit burst;
        // range ends, one/two-limb boundaries, trailing zero limbs, bit 6 toggling,
        // the full 40-limb result and every flavour of out-of-range argument
        directed_args = '{0, 1, 2, 3, 7, 8, 13, 20, 25, 63, 64, 99, 100,
                          101, 126, 127, 100, 0, 1, 5, 50};
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        n             = '0;
        args_sent     = 0;
        bad_args_sent = 0;
        largest_arg   = 0;
        drains        = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_args[i])
            send_arg(directed_args[i], i >= 12);
        drain_block();

        burst = 1'b0;
        for (int i = 0; i < RANDOM_ARGS; i++)
        begin
            if (i == RANDOM_ARGS / 2)
                drain_block();
            if (i % 16 == 0)
                burst = ($urandom_range(0, 3) == 0);
            // mostly short factorials to keep the run brisk, a fair share across
            // the full valid range and the rest over the whole 7-bit field
            pick = $urandom_range(0, 9);
            if (pick < 5)
                arg = $urandom_range(1, 30);
            else if (pick < 8)
                arg = $urandom_range(1, int'(MAX_ARG));
            else
                arg = $urandom_range(0, (1 << N_W) - 1);
            send_arg(arg, burst);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d arguments (%0d out of range, largest valid n %0d), %0d limb beats.",
                 args_sent, bad_args_sent, largest_arg, beats_taken);
        $display("Receiver held off %0d cycles once; sender drained the engine %0d times.",
                 HOLD_CYCLES, drains);
        if (fault_count == 0)
            $display("factorial_base10000_limbs_tb passed");
        else
            $display("factorial_base10000_limbs_tb failed");
        $finish;
    end

    // Receiver: random ready gaps per beat, with runs of zero gaps, and one long
    // hold-off so that the engine backs up and stops taking arguments.
    initial
    begin : receiver
        int gap;
        bit burst;
        out_ready   = 1'b0;
        beats_taken = 0;
        burst       = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (beats_taken % 24 == 0)
                burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            beats_taken++;
            if (beats_taken == HOLD_AT_BEAT)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
        end
    end

    // Watchdog: a long stretch with no beat on either channel means the engine is stuck.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timed out after %0d quiet cycles with %0d beats still due.",
                     quiet_cycles, outstanding);
            $display("factorial_base10000_limbs_tb failed");
            $finish;
        end
    end

endmodule
